@@ src/pixel_range_scale_12bit_core_macros.svh @@
// assertion macros for the pixel range scaler checker
// no dependencies; included by the checker file only
`ifndef PIXEL_RANGE_SCALE_12BIT_CORE_MACROS_SVH
`define PIXEL_RANGE_SCALE_12BIT_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PRS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/prs_pkg.sv @@
// shared types and constants of the pixel range scaler
// no dependencies; used by every module and interface of the block
package prs_pkg;

   localparam int PIX_W = 16;
   localparam int OP_W = 2;
   localparam int CSR_IDX_W = 1;
   localparam int PROD_W = 2 * PIX_W;

   // full-scale output code and its rounding half
   localparam logic [PIX_W-1:0] CODE_MAX = PIX_W'(4095);
   localparam logic [PIX_W-1:0] CODE_HALF = PIX_W'(4095 / 2);

   // operation codes
   localparam logic [OP_W-1:0] OP_OBSERVE = 2'd0;
   localparam logic [OP_W-1:0] OP_FORWARD = 2'd1;
   localparam logic [OP_W-1:0] OP_INVERSE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WIN_BASE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VALUE_RANGE = 1'd1;

   // one quotient bit per divider step
   localparam int DIV_STEPS = PIX_W;
   localparam int STEP_W = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

   typedef struct packed {
      logic load;
      logic mul;
      logic prep;
      logic step;
      logic emit;
   } prs_cmd_type;

   typedef struct packed {
      logic req_is_map;
      logic out_free;
   } prs_status_type;

endpackage

@@ src/prs_channels_if.sv @@
// valid/ready channel interfaces for request and response transactions
// depends on prs_pkg
interface prs_req_if;
   import prs_pkg::*;
   logic valid;
   logic ready;
   logic [OP_W-1:0] operation;
   logic [PIX_W-1:0] pixel;
   logic frame_start;

   modport source (output valid, output operation, output pixel, output frame_start,
                   input ready);
   modport sink (input valid, input operation, input pixel, input frame_start,
                 output ready);
endinterface

interface prs_rsp_if;
   import prs_pkg::*;
   logic valid;
   logic ready;
   logic [PIX_W-1:0] mapped_value;
   logic [PIX_W-1:0] lowest_seen;
   logic [PIX_W-1:0] highest_seen;
   logic any_seen;

   modport source (output valid, output mapped_value, output lowest_seen,
                   output highest_seen, output any_seen, input ready);
   modport sink (input valid, input mapped_value, input lowest_seen,
                 input highest_seen, input any_seen, output ready);
endinterface

@@ src/pixel_range_scale_12bit_core.sv @@
// top level of the 16-bit pixel range scaler with 12-bit codes
// depends on prs_pkg, prs_req_if, prs_rsp_if, prs_ctrl, prs_datapath
//
// the block takes one transaction at a time: observe folds a pixel into the
// running min/max, forward maps a pixel from the window [base,
// base+value_range] onto 0..4095 with rounding, inverse maps a code
// back to a raw value; each transaction gives exactly one response that
// also carries the running statistics. forward and inverse pass from
// acceptance through a multiply state, a state that adds the rounding
// term, the radix-2 restoring divider, a state that loads the output
// register and an idle state that takes the next transaction; observe
// and unused codes go from acceptance straight to the output-register
// state. the response waits in an output register, so a stalled response
// holds the block only in its final state. csr writes must come while idle.
module pixel_range_scale_12bit_core (
   input  logic                          clock,
   input  logic                          reset,
   prs_req_if.sink                       req_ch,
   prs_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [prs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [prs_pkg::PIX_W-1:0]     csr_wdata
);
   import prs_pkg::*;

   // command and status between sequencer and datapath
   prs_cmd_type    cmd;
   prs_status_type status;

   // sequencer: owns req ready and the divider step count
   prs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: config, statistics, arithmetic and the response register
   prs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_operation    (req_ch.operation),
      .req_pixel        (req_ch.pixel),
      .req_frame_start  (req_ch.frame_start),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_mapped_value (rsp_ch.mapped_value),
      .rsp_lowest_seen  (rsp_ch.lowest_seen),
      .rsp_highest_seen (rsp_ch.highest_seen),
      .rsp_any_seen     (rsp_ch.any_seen)
   );

endmodule

@@ src/prs_ctrl.sv @@
// sequencer of the pixel range scaler: accept, multiply, divide, emit
// depends on prs_pkg
module prs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  prs_pkg::prs_status_type status,
   output prs_pkg::prs_cmd_type    cmd
);
   import prs_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_PREP = 5'b00100,
      S_DIV  = 5'b01000,
      S_FIN  = 5'b10000
   } prs_state_type;

   prs_state_type state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.req_is_map ? S_MUL : S_FIN;
            end
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_LAST) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ src/prs_datapath.sv @@
// datapath: config registers, running statistics, multiplier, divider, output register
// depends on prs_pkg
module prs_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [prs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [prs_pkg::PIX_W-1:0]     csr_wdata,
   input  logic [prs_pkg::OP_W-1:0]      req_operation,
   input  logic [prs_pkg::PIX_W-1:0]     req_pixel,
   input  logic                          req_frame_start,
   input  prs_pkg::prs_cmd_type          cmd,
   output prs_pkg::prs_status_type       status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [prs_pkg::PIX_W-1:0]     rsp_mapped_value,
   output logic [prs_pkg::PIX_W-1:0]     rsp_lowest_seen,
   output logic [prs_pkg::PIX_W-1:0]     rsp_highest_seen,
   output logic                          rsp_any_seen
);
   import prs_pkg::*;

   logic [PIX_W-1:0]  win_base_ff, value_range_ff;
   logic [PIX_W-1:0]  run_min_ff, run_min_in, run_max_ff, run_max_in;
   logic              seen_ff, seen_in;
   logic [OP_W-1:0]   op_ff;
   logic [PIX_W-1:0]  pix_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PIX_W-1:0]  addend_ff, addend_in, divisor_ff, divisor_in;
   logic              zero_range_ff, below_ff, over_ff;
   logic [PIX_W-1:0]  rem_ff, rem_in, quo_ff, quo_in;
   logic              out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]  out_mapped_ff, out_low_ff, out_high_ff;
   logic              out_seen_ff;

   logic [PIX_W-1:0]  offset, code_clamped, mul_a, mul_b, result;
   logic              below, over;
   logic [PROD_W-1:0] numer;
   logic [PIX_W:0]    trial, inv_sum;
   logic              fits;

   assign status.req_is_map = (req_operation == OP_FORWARD) || (req_operation == OP_INVERSE);
   assign status.out_free = !out_valid_ff || rsp_ready;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_base_ff <= '0;
         value_range_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == REG_WIN_BASE) begin
            win_base_ff <= csr_wdata;
         end
         if (csr_index == REG_VALUE_RANGE) begin
            value_range_ff <= csr_wdata;
         end
      end
   end

   // running statistics
   always_comb begin
      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      seen_in = seen_ff;
      if (cmd.load && (req_operation == OP_OBSERVE)) begin
         seen_in = 1'b1;
         if (req_frame_start || !seen_ff) begin
            run_min_in = req_pixel;
            run_max_in = req_pixel;
         end else begin
            if (req_pixel < run_min_ff) run_min_in = req_pixel;
            if (req_pixel > run_max_ff) run_max_in = req_pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff <= '0;
         run_max_ff <= '0;
         seen_ff <= 1'b0;
      end else begin
         run_min_ff <= run_min_in;
         run_max_ff <= run_max_in;
         seen_ff <= seen_in;
      end
   end

   // operand select and multiply
   always_comb begin
      offset = pix_ff - win_base_ff;
      below = pix_ff < win_base_ff;
      over = offset >= value_range_ff;
      code_clamped = (pix_ff > CODE_MAX) ? CODE_MAX : pix_ff;
      if (op_ff == OP_FORWARD) begin
         mul_a = offset;
         mul_b = CODE_MAX;
         addend_in = {1'b0, value_range_ff[PIX_W-1:1]};
         divisor_in = value_range_ff;
      end else begin
         mul_a = code_clamped;
         mul_b = value_range_ff;
         addend_in = CODE_HALF;
         divisor_in = CODE_MAX;
      end
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // restoring divider, one quotient bit per step
   always_comb begin
      numer = prod_ff + PROD_W'(addend_ff);
      trial = {rem_ff, quo_ff[PIX_W-1]};
      fits = trial >= {1'b0, divisor_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.prep) begin
         rem_in = numer[PROD_W-1:PIX_W];
         quo_in = numer[PIX_W-1:0];
      end else if (cmd.step) begin
         rem_in = fits ? PIX_W'(trial - {1'b0, divisor_ff}) : trial[PIX_W-1:0];
         quo_in = {quo_ff[PIX_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_operation;
         pix_ff <= req_pixel;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
         addend_ff <= addend_in;
         divisor_ff <= divisor_in;
         zero_range_ff <= (value_range_ff == '0);
         below_ff <= below;
         over_ff <= over;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // final result select
   always_comb begin
      inv_sum = {1'b0, quo_ff} + {1'b0, win_base_ff};
      case (op_ff)
         OP_FORWARD: begin
            if (zero_range_ff || below_ff) result = '0;
            else if (over_ff) result = CODE_MAX;
            else result = quo_ff;
         end
         OP_INVERSE: begin
            if (zero_range_ff) result = win_base_ff;
            else if (inv_sum[PIX_W]) result = '1;
            else result = inv_sum[PIX_W-1:0];
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_mapped_ff <= result;
         out_low_ff <= run_min_ff;
         out_high_ff <= run_max_ff;
         out_seen_ff <= seen_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_mapped_value = out_mapped_ff;
   assign rsp_lowest_seen = out_low_ff;
   assign rsp_highest_seen = out_high_ff;
   assign rsp_any_seen = out_seen_ff;

endmodule

@@ src/prs_checker.sv @@
// port-level checks of the pixel range scaler, bound to the top level
// depends on prs_pkg and pixel_range_scale_12bit_core_macros.svh
`include "pixel_range_scale_12bit_core_macros.svh"

module prs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [prs_pkg::PIX_W-1:0] rsp_lowest_seen,
   input logic [prs_pkg::PIX_W-1:0] rsp_highest_seen,
   input logic                      rsp_any_seen
);
   import prs_pkg::*;

   // a pending response stays offered
   `PRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   // one transaction at a time
   `PRS_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request accepted while busy")

   // statistics read zero until a pixel is observed
   `PRS_ASSERT_IMPL(a_empty_stats, clock, reset, rsp_valid && !rsp_any_seen, (rsp_lowest_seen == '0) && (rsp_highest_seen == '0), "statistics nonzero before any observe")

   // running minimum never passes the maximum
   `PRS_ASSERT_IMPL(a_min_le_max, clock, reset, rsp_valid, rsp_lowest_seen <= rsp_highest_seen, "running min above running max")

endmodule

bind pixel_range_scale_12bit_core prs_checker u_prs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_lowest_seen  (rsp_ch.lowest_seen),
   .rsp_highest_seen (rsp_ch.highest_seen),
   .rsp_any_seen     (rsp_ch.any_seen)
);

@@ dv/pixel_range_scale_12bit_core_tb.sv @@
// self-checking testbench for pixel_range_scale_12bit_core: observe, forward and inverse
// transactions are checked against an in-bench model of the window mapping and running min/max
// depends on prs_pkg, prs_req_if, prs_rsp_if and pixel_range_scale_12bit_core from the rtl source folder
`timescale 1ns / 1ps

module pixel_range_scale_12bit_core_tb;
   import prs_pkg::*;

   // the fourth operation code is not assigned; the block must pass it through harmlessly
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // settle wait covers a forward or inverse transaction from acceptance to the next acceptance
   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASE_COUNT = 6;
   localparam int PHASE_ITEMS = 115;

   typedef struct {
      logic [PIX_W-1:0] mapped_value;
      logic [PIX_W-1:0] lowest_seen;
      logic [PIX_W-1:0] highest_seen;
      logic             any_seen;
   } scale_result_type;

   // window mapping model plus running statistics; holds what each response must carry
   class range_scale_sb_type;
      logic [PIX_W-1:0] win_min;
      logic [PIX_W-1:0] win_range;
      logic [PIX_W-1:0] run_min;
      logic [PIX_W-1:0] run_max;
      logic             seen;
      scale_result_type pending_rsp[$];
      int               error_count;
      int               op_count[4];
      int               window_writes;

      function new();
         win_min = '0;
         win_range = '0;
         run_min = '0;
         run_max = '0;
         seen = 1'b0;
         error_count = 0;
         window_writes = 0;
         foreach (op_count[i]) op_count[i] = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [PIX_W-1:0] data);
         if (idx == REG_WIN_BASE) win_min = data;
         else if (idx == REG_VALUE_RANGE) win_range = data;
         window_writes++;
      endfunction

      function logic [PIX_W-1:0] forward_code(logic [PIX_W-1:0] pix);
         longint unsigned span;
         longint unsigned q;
         if (win_range == 0 || pix < win_min) return '0;
         span = longint'(pix) - longint'(win_min);
         q = (span * longint'(CODE_MAX) + longint'(win_range / 2)) / longint'(win_range);
         if (q > longint'(CODE_MAX)) q = longint'(CODE_MAX);
         return PIX_W'(q);
      endfunction

      function logic [PIX_W-1:0] inverse_value(logic [PIX_W-1:0] code);
         longint unsigned c;
         longint unsigned q;
         c = (code > CODE_MAX) ? longint'(CODE_MAX) : longint'(code);
         if (win_range == 0) return win_min;
         q = (c * longint'(win_range) + longint'(CODE_HALF)) / longint'(CODE_MAX);
         q = q + longint'(win_min);
         if (q > 64'd65535) q = 64'd65535;
         return PIX_W'(q);
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [PIX_W-1:0] pix, logic fs);
         scale_result_type r;
         r.mapped_value = '0;
         if (op == OP_OBSERVE) begin
            if (fs || !seen) begin
               run_min = pix;
               run_max = pix;
            end else begin
               if (pix < run_min) run_min = pix;
               if (pix > run_max) run_max = pix;
            end
            seen = 1'b1;
         end else if (op == OP_FORWARD) begin
            r.mapped_value = forward_code(pix);
         end else if (op == OP_INVERSE) begin
            r.mapped_value = inverse_value(pix);
         end
         r.lowest_seen = run_min;
         r.highest_seen = run_max;
         r.any_seen = seen;
         pending_rsp.push_back(r);
         op_count[op]++;
      endfunction

      task report(string what);
         $display("%0t ns  mismatch: %s", $time, what);
         error_count++;
      endtask

      task check_response(scale_result_type got);
         scale_result_type want;
         if (pending_rsp.size() == 0) begin
            report($sformatf("unexpected response mapped=%0d", got.mapped_value));
         end else begin
            want = pending_rsp.pop_front();
            if (got.mapped_value !== want.mapped_value)
               report($sformatf("mapped_value got %0d want %0d",
                                got.mapped_value, want.mapped_value));
            if (got.lowest_seen !== want.lowest_seen)
               report($sformatf("lowest_seen got %0d want %0d",
                                got.lowest_seen, want.lowest_seen));
            if (got.highest_seen !== want.highest_seen)
               report($sformatf("highest_seen got %0d want %0d",
                                got.highest_seen, want.highest_seen));
            if (got.any_seen !== want.any_seen)
               report($sformatf("any_seen got %0b want %0b", got.any_seen, want.any_seen));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [PIX_W-1:0]     csr_wdata;

   prs_req_if req_ch ();
   prs_rsp_if rsp_ch ();

   range_scale_sb_type sb = new();

   // idle percentages per phase, read by the sender task and the response-side process
   int send_idle_pct = 20;
   int recv_idle_pct = 58;
   // bumping this asks the response side for one long hold-off
   int hold_req_count = 0;

   pixel_range_scale_12bit_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // response side: ready changes at the falling edge; a requested hold-off is counted here
   initial begin : rsp_ready_driver
      int hold_seen_count;
      int hold_left;
      hold_seen_count = 0;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req_count != hold_seen_count) begin
            hold_seen_count = hold_req_count;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (reset) begin
            rsp_ch.ready = 1'b0;
         end else if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // response monitor: a transaction completes at a rising edge with valid and ready high
   always @(posedge clock) begin
      scale_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.mapped_value = rsp_ch.mapped_value;
         got.lowest_seen = rsp_ch.lowest_seen;
         got.highest_seen = rsp_ch.highest_seen;
         got.any_seen = rsp_ch.any_seen;
         sb.check_response(got);
      end
   end

   // offer one request transaction; called and returns at a falling edge
   task automatic send_txn(logic [OP_W-1:0] op, logic [PIX_W-1:0] pix, logic fs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.operation = op;
      req_ch.pixel = pix;
      req_ch.frame_start = fs;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(op, pix, fs);
      @(negedge clock);
   endtask

   // stop offering, wait for every outstanding response, then let the datapath settle
   task automatic wait_idle();
      req_ch.valid = 1'b0;
      while (sb.pending_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [PIX_W-1:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      sb.set_register(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // window changes only ever happen with the block idle
   task automatic set_window(logic [PIX_W-1:0] lo, logic [PIX_W-1:0] span);
      wait_idle();
      write_csr(REG_WIN_BASE, lo);
      write_csr(REG_VALUE_RANGE, span);
   endtask

   // one random transaction, biased toward the interesting parts of the current window
   task automatic random_txn();
      int r;
      int spread;
      logic [OP_W-1:0] op;
      logic [PIX_W-1:0] pix;
      logic fs;
      r = $urandom_range(99);
      if (r < 35) op = OP_OBSERVE;
      else if (r < 65) op = OP_FORWARD;
      else if (r < 95) op = OP_INVERSE;
      else op = OP_UNUSED;
      fs = ($urandom_range(9) == 0);
      pix = PIX_W'($urandom);
      if (op == OP_FORWARD && $urandom_range(3) != 0) begin
         // around the window, including a little below and above it
         spread = int'(sb.win_range) + 64;
         pix = PIX_W'(int'(sb.win_min) + int'($urandom_range(spread)) - 32);
      end else if (op == OP_INVERSE && $urandom_range(3) != 0) begin
         pix = PIX_W'($urandom_range(4095));
      end
      send_txn(op, pix, fs);
   endtask

   // hard stop in case the block hangs
   initial begin : watchdog
      #2000000;
      $display("pixel_range_scale_12bit_core_tb: errors");
      $finish;
   end

   initial begin : stimulus
      int waited;
      logic [PIX_W-1:0] lo;
      logic [PIX_W-1:0] span;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.operation = OP_OBSERVE;
      req_ch.pixel = '0;
      req_ch.frame_start = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset window (min 0, range 0), nothing observed yet
      send_txn(OP_FORWARD, 16'hABCD, 1'b0);   // zero range forward, stats still empty
      send_txn(OP_INVERSE, 16'h0FFF, 1'b0);   // zero range inverse returns min
      send_txn(OP_UNUSED, 16'h5555, 1'b0);    // unused code leaves state alone
      send_txn(OP_OBSERVE, 16'h1234, 1'b0);   // first observation seeds min and max
      send_txn(OP_OBSERVE, 16'hFFFF, 1'b0);
      send_txn(OP_OBSERVE, 16'h0000, 1'b0);
      send_txn(OP_OBSERVE, 16'h8000, 1'b1);   // frame start restarts statistics
      send_txn(OP_FORWARD, 16'h8000, 1'b1);   // frame start ignored on map operations
      send_txn(OP_INVERSE, 16'h07FF, 1'b1);

      // directed: ordinary window, edges and saturation
      set_window(16'd1000, 16'd3000);
      send_txn(OP_FORWARD, 16'd999, 1'b0);    // below window
      send_txn(OP_FORWARD, 16'd1000, 1'b0);
      send_txn(OP_FORWARD, 16'd2500, 1'b0);
      send_txn(OP_FORWARD, 16'd4000, 1'b0);
      send_txn(OP_FORWARD, 16'd4001, 1'b0);   // above window
      send_txn(OP_FORWARD, 16'hFFFF, 1'b0);
      send_txn(OP_INVERSE, 16'd0, 1'b0);
      send_txn(OP_INVERSE, 16'd2048, 1'b0);
      send_txn(OP_INVERSE, 16'd4096, 1'b0);   // code clamped to full scale
      send_txn(OP_INVERSE, 16'hFFFF, 1'b0);

      // directed: both registers at their maximum, inverse overflows
      set_window(16'hFFFF, 16'hFFFF);
      send_txn(OP_INVERSE, 16'd4095, 1'b0);
      send_txn(OP_INVERSE, 16'd0, 1'b0);
      send_txn(OP_FORWARD, 16'hFFFF, 1'b0);

      // directed: full-width window from zero
      set_window(16'd0, 16'hFFFF);
      send_txn(OP_FORWARD, 16'hFFFF, 1'b0);
      send_txn(OP_FORWARD, 16'd1, 1'b0);
      send_txn(OP_INVERSE, 16'd4095, 1'b0);

      // random phases: window changes between phases, idle pattern changes every two
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: begin lo = 16'd0; span = 16'hFFFF; end
            1: begin lo = PIX_W'($urandom_range(20000)); span = PIX_W'($urandom_range(40000)); end
            2: begin lo = 16'hFFFF; span = 16'd0; end
            3: begin lo = PIX_W'($urandom_range(30000)); span = 16'd0; end
            4: begin lo = 16'd0; span = 16'd4095; end
            default: begin lo = PIX_W'($urandom); span = PIX_W'($urandom); end
         endcase
         set_window(lo, span);
         if (ph < 2) begin
            send_idle_pct = 20;
            recv_idle_pct = 58;
         end else if (ph < 4) begin
            send_idle_pct = 58;
            recv_idle_pct = 20;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long response stall while requests keep coming, so the input backs up
            if (ph == 1 && n == 20) hold_req_count++;
            // request side goes quiet until everything outstanding has returned
            if (ph == 2 && n == 60) wait_idle();
            random_txn();
         end
      end

      // drain with a bound, then give the datapath time to show any stray response
      req_ch.valid = 1'b0;
      waited = 0;
      while (sb.pending_rsp.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.pending_rsp.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.pending_rsp.size()));

      $display("covered %0d observe, %0d forward, %0d inverse, %0d unused-code transactions",
               sb.op_count[OP_OBSERVE], sb.op_count[OP_FORWARD],
               sb.op_count[OP_INVERSE], sb.op_count[OP_UNUSED]);
      $display("across %0d register writes, with mismatch count %0d",
               sb.window_writes, sb.error_count);
      if (sb.error_count == 0) begin
         $display("pixel_range_scale_12bit_core_tb: clean");
      end else begin
         $display("pixel_range_scale_12bit_core_tb: errors");
      end
      $finish;
   end

endmodule
